### hw/rtl/trr_pkg.sv
// Package for the telemetry request responder.
// Holds the frame constants and the store access structs; no dependencies.
package trr_pkg;

    localparam int FRAME_BYTES = 45;
    localparam int STORE_SPAN  = 41;
    localparam int STORE_DEPTH = 2 * STORE_SPAN;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = $clog2(FRAME_BYTES);

    localparam logic [POS_W-1:0] POS_START  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_MODULE = POS_W'(1);
    localparam logic [POS_W-1:0] POS_FIRST  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_ID     = POS_W'(3);
    localparam logic [POS_W-1:0] POS_LAST_S = POS_W'(42);
    localparam logic [POS_W-1:0] POS_STOP   = POS_W'(43);
    localparam logic [POS_W-1:0] POS_SUM    = POS_W'(FRAME_BYTES - 1);

    localparam logic [ADDR_W-1:0] GPS_BASE = ADDR_W'(STORE_SPAN);

    localparam logic [7:0] BYTE_BIN_REQ = 8'h80;
    localparam logic [7:0] BYTE_TXT_REQ = 8'h7F;
    localparam logic [7:0] BYTE_GAM     = 8'h8D;
    localparam logic [7:0] BYTE_GPS     = 8'h8A;
    localparam logic [7:0] BYTE_START   = 8'h7C;
    localparam logic [7:0] BYTE_STOP    = 8'h7D;
    localparam logic [7:0] ID_GAM       = 8'hD0;
    localparam logic [7:0] ID_GPS       = 8'hA0;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic       written;
        logic [7:0] data;
    } t_rd_rsp;

    typedef struct packed {
        logic start;
        logic sel;
    } t_frame_cmd;

endpackage

### hw/rtl/trr_store.sv
// Payload store: 82 x 8 synchronous memory with registered read data.
// Per-entry written bits are read out beside the data. Uses trr_pkg.
module trr_store (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  trr_pkg::t_wr_req i_wr,
    input  trr_pkg::t_rd_req i_rd,
    output trr_pkg::t_rd_rsp o_rsp
);

    logic [7:0]                      r_mem [trr_pkg::STORE_DEPTH];
    logic [trr_pkg::STORE_DEPTH-1:0] r_written;
    logic [7:0]                      r_rdata;
    logic                            r_rwritten;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written  <= '0;
            r_rwritten <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_written[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rwritten <= r_written[i_rd.addr];
            end
        end
    end

    assign o_rsp.written = r_rwritten;
    assign o_rsp.data    = r_rdata;

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr.en && i_rd.en))
        else $error("store read and write in the same cycle");

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.en |-> (i_wr.addr < trr_pkg::ADDR_W'(trr_pkg::STORE_DEPTH)))
        else $error("store write address out of range");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd.en |-> (i_rd.addr < trr_pkg::ADDR_W'(trr_pkg::STORE_DEPTH)))
        else $error("store read address out of range");

endmodule

### hw/rtl/trr_framer.sv
// Reply framer: steps through the 45 frame positions, reads stored bytes one
// ahead, accumulates the checksum and drives the output register. Uses trr_pkg.
module trr_framer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trr_pkg::t_frame_cmd i_cmd,
    input  trr_pkg::t_rd_rsp    i_rsp,
    output trr_pkg::t_rd_req    o_rd,
    output logic                o_busy,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [7:0]          o_m_tdata,
    output logic                o_m_tlast
);

    logic                      r_busy;
    logic                      r_sel;
    logic [trr_pkg::POS_W-1:0] r_pos;
    logic [7:0]                r_sum;
    logic                      r_m_valid;
    logic [7:0]                r_m_data;
    logic                      r_m_last;

    logic                      n_advance;
    logic [7:0]                n_byte;
    logic [trr_pkg::ADDR_W-1:0] n_rd_addr;

    assign n_advance = r_busy && (!r_m_valid || i_m_tready);

    always_comb begin
        priority if (r_pos == trr_pkg::POS_START) begin
            n_byte = trr_pkg::BYTE_START;
        end else if (r_pos == trr_pkg::POS_MODULE) begin
            n_byte = r_sel ? trr_pkg::BYTE_GPS : trr_pkg::BYTE_GAM;
        end else if (r_pos == trr_pkg::POS_ID) begin
            n_byte = r_sel ? trr_pkg::ID_GPS : trr_pkg::ID_GAM;
        end else if (r_pos == trr_pkg::POS_STOP) begin
            n_byte = trr_pkg::BYTE_STOP;
        end else if (r_pos == trr_pkg::POS_SUM) begin
            n_byte = r_sum;
        end else begin
            n_byte = i_rsp.written ? i_rsp.data : 8'h00;
        end
    end

    // read address of the next position: base + (pos + 1 - 2)
    assign n_rd_addr = trr_pkg::ADDR_W'(r_pos) - trr_pkg::ADDR_W'(1)
                     + (r_sel ? trr_pkg::GPS_BASE : '0);
    assign o_rd.en   = n_advance && (r_pos >= trr_pkg::POS_MODULE)
                     && (r_pos < trr_pkg::POS_LAST_S);
    assign o_rd.addr = n_rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_sel     <= 1'b0;
            r_pos     <= trr_pkg::POS_START;
            r_sum     <= 8'h00;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cmd.start && !r_busy) begin
                r_busy <= 1'b1;
                r_sel  <= i_cmd.sel;
                r_pos  <= trr_pkg::POS_START;
                r_sum  <= 8'h00;
            end else if (n_advance) begin
                r_sum <= r_sum + n_byte;
                if (r_pos == trr_pkg::POS_SUM) begin
                    r_busy <= 1'b0;
                    r_pos  <= trr_pkg::POS_START;
                end else begin
                    r_pos <= r_pos + trr_pkg::POS_W'(1);
                end
            end
            if (n_advance) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_advance) begin
            r_m_data <= n_byte;
            r_m_last <= (r_pos == trr_pkg::POS_SUM);
        end
    end

    assign o_busy     = r_busy;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= trr_pkg::POS_SUM)
        else $error("frame position out of range");

    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_pos == trr_pkg::POS_START))
        else $error("position not parked while idle");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_advance && r_pos == trr_pkg::POS_SUM) |=> (!r_busy && r_m_valid && r_m_last))
        else $error("checksum beat did not close the frame");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_cmd.start)
        else $error("frame start while busy");

endmodule

### hw/rtl/telemetry_request_responder_unit.sv
// Top level of the telemetry request responder: request parser, enables,
// payload store and reply framer. Uses trr_pkg, trr_store and trr_framer.
//
//  channel   dir  handshake                 payload
//  s stream  in   i_s_tvalid / o_s_tready   tdata, tuser
//  m stream  out  o_m_tvalid / i_m_tready   tdata, tlast
//  cfg       in   i_cfg_we                  i_cfg_index, i_cfg_data
//
// A request that is answered is accepted, then gives one beat per frame
// position, paced by the output register loading one position a cycle
// whenever it is empty or i_m_tready takes the held beat.
// Input is held off (o_s_tready low) until the checksum beat is loaded.
// Synchronous active-low reset clears the parser, enables and written bits.
module telemetry_request_responder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // line_byte[7:0], byte_index[13:8], payload_value[21:14]
    input  logic [1:0]  i_s_tuser,   // mode[0], module_sel[1]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // out_byte[7:0]
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_BINARY = 2'd1;
    localparam logic [1:0] ST_TEXT   = 2'd2;

    localparam logic CFG_GAM_EN = 1'b0;
    localparam logic CFG_GPS_EN = 1'b1;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_gam_en;
    logic       r_gps_en;

    logic       n_accept;
    logic       n_mode;
    logic       n_sel;
    logic [7:0] n_line;
    logic [5:0] n_idx;
    logic [7:0] n_val;
    logic       busy;

    trr_pkg::t_wr_req    n_wr;
    trr_pkg::t_rd_req    rd;
    trr_pkg::t_rd_rsp    rsp;
    trr_pkg::t_frame_cmd n_cmd;

    assign n_mode = i_s_tuser[0];
    assign n_sel  = i_s_tuser[1];
    assign n_line = i_s_tdata[7:0];
    assign n_idx  = i_s_tdata[13:8];
    assign n_val  = i_s_tdata[21:14];

    assign o_s_tready = !busy;
    assign n_accept   = i_s_tvalid && !busy;

    assign n_wr.en   = n_accept && n_mode && (n_idx >= trr_pkg::POS_FIRST)
                     && (n_idx <= trr_pkg::POS_LAST_S) && (n_idx != trr_pkg::POS_ID);
    assign n_wr.addr = trr_pkg::ADDR_W'(n_idx) - trr_pkg::ADDR_W'(trr_pkg::POS_FIRST)
                     + (n_sel ? trr_pkg::GPS_BASE : '0);
    assign n_wr.data = n_val;

    always_comb begin
        n_state   = r_state;
        n_cmd     = '0;
        if (n_accept && !n_mode) begin
            unique case (r_state)
                ST_IDLE: begin
                    if (n_line == trr_pkg::BYTE_BIN_REQ) begin
                        n_state = ST_BINARY;
                    end else if (n_line == trr_pkg::BYTE_TXT_REQ) begin
                        n_state = ST_TEXT;
                    end
                end
                ST_BINARY: begin
                    n_state = ST_IDLE;
                    if (n_line == trr_pkg::BYTE_GAM && r_gam_en) begin
                        n_cmd.start = 1'b1;
                        n_cmd.sel   = 1'b0;
                    end else if (n_line == trr_pkg::BYTE_GPS && r_gps_en) begin
                        n_cmd.start = 1'b1;
                        n_cmd.sel   = 1'b1;
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_gam_en <= 1'b0;
            r_gps_en <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GAM_EN: r_gam_en <= i_cfg_data;
                    CFG_GPS_EN: r_gps_en <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    trr_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (n_wr),
        .i_rd    (rd),
        .o_rsp   (rsp)
    );

    trr_framer u_framer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (n_cmd),
        .i_rsp      (rsp),
        .o_rd       (rd),
        .o_busy     (busy),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    a_state_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != 2'd3)
        else $error("parser in unused state");

    a_start_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_cmd.start |=> (r_state == ST_IDLE && busy))
        else $error("reply start did not take the framer");

    a_busy_blocks_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !n_wr.en)
        else $error("payload write during reply");

endmodule

### verif/tb_top.sv
// Self-checking testbench for telemetry_request_responder_unit.
// Predicts reply frames from line bytes, payload writes and enables;
// depends on trr_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [1:0] {
        LINK_IDLE,
        LINK_BINARY,
        LINK_TEXT
    } t_link_state;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_reply_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;   // line_byte[7:0], byte_index[13:8], payload_value[21:14]
    logic [1:0]  i_s_tuser;   // mode[0], module_sel[1]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;   // out_byte[7:0]
    logic        o_m_tlast;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic        i_cfg_data;

    telemetry_request_responder_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_reply_beat reply_q[$];
    t_link_state link_state;
    logic [7:0]  payload_mem [trr_pkg::STORE_DEPTH];
    logic        gam_en;
    logic        gps_en;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int items_sent;
    int mismatches;
    int quiet_cycles;

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Build the reply frame for one module from the current store.
    task automatic push_frame(input logic sel);
        logic [7:0]  frame [trr_pkg::FRAME_BYTES];
        logic [7:0]  sum;
        t_reply_beat beat;
        sum = 8'h00;
        frame[0] = trr_pkg::BYTE_START;
        frame[1] = sel ? trr_pkg::BYTE_GPS : trr_pkg::BYTE_GAM;
        for (int i = 2; i <= 42; i++) begin
            frame[i] = payload_mem[sel * trr_pkg::STORE_SPAN + i - 2];
        end
        frame[3] = sel ? trr_pkg::ID_GPS : trr_pkg::ID_GAM;
        frame[43] = trr_pkg::BYTE_STOP;
        for (int i = 0; i < trr_pkg::FRAME_BYTES - 1; i++) begin
            sum = sum + frame[i];
        end
        frame[trr_pkg::FRAME_BYTES - 1] = sum;
        for (int i = 0; i < trr_pkg::FRAME_BYTES; i++) begin
            beat.data = frame[i];
            beat.last = (i == trr_pkg::FRAME_BYTES - 1);
            reply_q.push_back(beat);
        end
    endtask

    task automatic predict_reply(input logic mode, input logic [7:0] line,
                                 input logic sel, input logic [5:0] idx,
                                 input logic [7:0] val);
        if (mode) begin
            if (idx >= 2 && idx <= 42 && idx != 3) begin
                payload_mem[sel * trr_pkg::STORE_SPAN + idx - 2] = val;
            end
        end else begin
            case (link_state)
                LINK_IDLE: begin
                    if (line == trr_pkg::BYTE_BIN_REQ) begin
                        link_state = LINK_BINARY;
                    end else if (line == trr_pkg::BYTE_TXT_REQ) begin
                        link_state = LINK_TEXT;
                    end
                end
                LINK_BINARY: begin
                    link_state = LINK_IDLE;
                    if (line == trr_pkg::BYTE_GAM && gam_en) begin
                        push_frame(1'b0);
                    end else if (line == trr_pkg::BYTE_GPS && gps_en) begin
                        push_frame(1'b1);
                    end
                end
                default: begin
                    link_state = LINK_IDLE;
                end
            endcase
        end
    endtask

    task automatic send_item(input logic mode, input logic [7:0] line,
                             input logic sel, input logic [5:0] idx,
                             input logic [7:0] val);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        repeat (gap) @(negedge i_clk) i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, val, idx, line};
        i_s_tuser  <= {sel, mode};
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        items_sent++;
        predict_reply(mode, line, sel, idx, val);
    endtask

    task automatic send_line(input logic [7:0] line);
        send_item(1'b0, line, 1'($urandom), 6'($urandom), 8'($urandom));
    endtask

    task automatic send_write(input logic sel, input logic [5:0] idx, input logic [7:0] val);
        send_item(1'b1, 8'($urandom), sel, idx, val);
    endtask

    // Hold the sender until every expected beat is out, then let the unit settle.
    task automatic wait_drain();
        @(negedge i_clk) i_s_tvalid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_enables(input logic gam, input logic gps);
        wait_drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= 1'b0;
        i_cfg_data  <= gam;
        gam_en = gam;
        @(negedge i_clk);
        i_cfg_index <= 1'b1;
        i_cfg_data  <= gps;
        gps_en = gps;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Return receiver beats: compare against the oldest expected beat.
    always @(posedge i_clk) begin
        t_reply_beat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (reply_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected beat: data %02h last %0b", o_m_tdata, o_m_tlast);
                end
            end else begin
                want = reply_q.pop_front();
                if (want.data !== o_m_tdata || want.last !== o_m_tlast) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("beat mismatch: expected data %02h last %0b, got %02h last %0b",
                                 want.data, want.last, o_m_tdata, o_m_tlast);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic test_reset_disabled();
        send_line(trr_pkg::BYTE_BIN_REQ);
        send_line(trr_pkg::BYTE_GAM);
        send_line(trr_pkg::BYTE_BIN_REQ);
        send_line(trr_pkg::BYTE_GPS);
    endtask

    task automatic test_directed_frames();
        write_enables(1'b1, 1'b1);
        send_write(1'b0, 6'd2, 8'hFF);
        send_write(1'b0, 6'd42, 8'hFF);
        send_write(1'b1, 6'd2, 8'hFF);
        send_write(1'b1, 6'd42, 8'h00);
        send_write(1'b0, 6'd3, 8'h55);
        send_write(1'b1, 6'd0, 8'h11);
        send_write(1'b0, 6'd43, 8'h22);
        send_write(1'b1, 6'd63, 8'h33);
        send_line(trr_pkg::BYTE_BIN_REQ);
        send_line(trr_pkg::BYTE_GAM);
        send_line(trr_pkg::BYTE_BIN_REQ);
        send_line(trr_pkg::BYTE_GPS);
    endtask

    task automatic test_protocol_corners();
        send_line(8'h00);
        send_line(8'hFF);
        send_line(trr_pkg::BYTE_TXT_REQ);
        send_line(trr_pkg::BYTE_BIN_REQ);
        send_line(trr_pkg::BYTE_GAM);
        send_line(trr_pkg::BYTE_BIN_REQ);
        send_line(trr_pkg::BYTE_BIN_REQ);
        send_line(trr_pkg::BYTE_BIN_REQ);
        send_write(1'b1, 6'd20, 8'hA5);
        send_line(trr_pkg::BYTE_GPS);
    endtask

    task automatic random_traffic(input int n_items);
        int   stop_at;
        int   pick;
        logic sel;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            sel  = 1'($urandom);
            if (pick < 40) begin
                if ($urandom_range(9) == 0) begin
                    send_write(sel, 6'($urandom_range(63, 0)), 8'($urandom));
                end else begin
                    send_write(sel, 6'($urandom_range(42, 2)), 8'($urandom));
                end
            end else if (pick < 78) begin
                send_line(trr_pkg::BYTE_BIN_REQ);
                if ($urandom_range(9) == 0) begin
                    send_line(8'($urandom));
                end else begin
                    send_line(sel ? trr_pkg::BYTE_GPS : trr_pkg::BYTE_GAM);
                end
            end else if (pick < 88) begin
                send_line(trr_pkg::BYTE_TXT_REQ);
                send_line(8'($urandom));
            end else begin
                send_line(8'($urandom));
            end
        end
    endtask

    task automatic test_random_phases();
        write_enables(1'b1, 1'b1);
        send_idle_pct = 38;
        recv_idle_pct = 82;
        random_traffic(75);
        write_enables(1'b1, 1'b0);
        send_idle_pct = 82;
        recv_idle_pct = 38;
        random_traffic(75);
        write_enables(1'b0, 1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(75);
    endtask

    task automatic test_backpressure();
        write_enables(1'b1, 1'b1);
        @(posedge i_clk);
        hold_cycles = HOLD_OFF_CYCLES;
        for (int i = 0; i < 4; i++) begin
            send_write(1'($urandom), 6'($urandom_range(42, 2)), 8'($urandom));
            send_line(trr_pkg::BYTE_BIN_REQ);
            send_line(i[0] ? trr_pkg::BYTE_GPS : trr_pkg::BYTE_GAM);
        end
        wait_drain();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_m_tready  = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data  = 1'b0;
        link_state  = LINK_IDLE;
        gam_en      = 1'b0;
        gps_en      = 1'b0;
        send_idle_pct = 38;
        recv_idle_pct = 82;
        hold_cycles   = 0;
        items_sent    = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        for (int i = 0; i < trr_pkg::STORE_DEPTH; i++) begin
            payload_mem[i] = 8'h00;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_reset_disabled();
        test_directed_frames();
        test_protocol_corners();
        test_random_phases();
        test_backpressure();

        wait_drain();
        if (mismatches == 0 && reply_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
